FILE: rtl/cpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  // Register indexes on the configuration port
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  localparam logic POLICY_PLAIN    = 1'b0;
  localparam logic POLICY_MODIFIED = 1'b1;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_FAULT  = 1'b1;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

  typedef enum logic [2:0] {
    OUT_ACC_HIT   = 3'd0,
    OUT_ACC_MISS  = 3'd1,
    OUT_RESIDENT  = 3'd2,
    OUT_PLACED    = 3'd3,
    OUT_REPLACED  = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SEEK,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic filled;
    logic used;
    logic modified;
  } flags_t;

endpackage

`default_nettype wire

FILE: rtl/clock_page_replacement.sv
`timescale 1ns / 1ps
`default_nettype none

// Working-set page table with clock / enhanced second-chance replacement.
// Input channel (in_valid/in_stall) carries command, page_number, is_write;
// output channel (out_valid/out_stall) returns one result per item:
// outcome, slot, victim_page, victim_dirty, hand_after.
// Config writes (cfg_write, cfg_index, cfg_data) set policy_mode (index 0)
// and table_limit (index 1); write them only while the block is idle.
// The entries sit in a ring of SLOTS cells that turns one cell per cycle
// while shift is high; the controller sees only the head cell. One item
// is worked at a time: lookup is a full ring lap, after which an access
// or a fault on a resident page has its result ready. A fault that places
// a page then turns the ring to the free slot; a replacement turns it to
// the hand and then sweeps on for a victim.
// The output register lets a finished result wait while the next item is
// accepted; that item's result waits in turn while out_stall is high.
// Reset (rst, synchronous) empties the table, parks the hand at slot 0 and
// restores plain clock with a limit of 16.
module clock_page_replacement #(
  parameter int SLOTS = 16,
  parameter int PAGE_BITS = 20,
  localparam int SW = $clog2(SLOTS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [4:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 command,
  input  wire logic [PAGE_BITS-1:0] page_number,
  input  wire logic                 is_write,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                outcome,
  output logic [SW-1:0]             slot,
  output logic [PAGE_BITS-1:0]      victim_page,
  output logic                      victim_dirty,
  output logic [SW-1:0]             hand_after
);

  logic [SW-1:0]        cell_slot  [SLOTS];
  cpr_pkg::flags_t      cell_flags [SLOTS];
  logic [PAGE_BITS-1:0] cell_page  [SLOTS];

  logic                 shift;
  logic [SW-1:0]        tail_slot;
  cpr_pkg::flags_t      tail_flags;
  logic [PAGE_BITS-1:0] tail_page;

  for (genvar i = 0; i < SLOTS; i++) begin : g_ring
    if (i == SLOTS - 1) begin : g_tail
      cpr_cell #(.SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS), .INDEX(i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .next_slot  (tail_slot),
        .next_flags (tail_flags),
        .next_page  (tail_page),
        .slot_id    (cell_slot[i]),
        .flags      (cell_flags[i]),
        .page       (cell_page[i])
      );
    end else begin : g_body
      cpr_cell #(.SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS), .INDEX(i)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (shift),
        .next_slot  (cell_slot[i+1]),
        .next_flags (cell_flags[i+1]),
        .next_page  (cell_page[i+1]),
        .slot_id    (cell_slot[i]),
        .flags      (cell_flags[i]),
        .page       (cell_page[i])
      );
    end
  end

  cpr_ctrl #(.SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .page_number  (page_number),
    .is_write     (is_write),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .outcome      (outcome),
    .slot         (slot),
    .victim_page  (victim_page),
    .victim_dirty (victim_dirty),
    .hand_after   (hand_after),
    .head_slot    (cell_slot[0]),
    .head_flags   (cell_flags[0]),
    .head_page    (cell_page[0]),
    .shift        (shift),
    .tail_slot    (tail_slot),
    .tail_flags   (tail_flags),
    .tail_page    (tail_page)
  );

endmodule

`default_nettype wire

FILE: rtl/cpr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the rotating table. The slot id travels with the entry.
module cpr_cell #(
  parameter int SLOTS = 16,
  parameter int PAGE_BITS = 20,
  parameter int INDEX = 0,
  localparam int SW = $clog2(SLOTS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 shift,
  input  wire logic [SW-1:0]        next_slot,
  input  wire cpr_pkg::flags_t      next_flags,
  input  wire logic [PAGE_BITS-1:0] next_page,
  output logic [SW-1:0]             slot_id,
  output cpr_pkg::flags_t           flags,
  output logic [PAGE_BITS-1:0]      page
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_id <= SW'(INDEX);
      flags   <= '0;
    end else if (shift) begin
      slot_id <= next_slot;
      flags   <= next_flags;
    end
  end

  // page is unknown until the slot is first filled
  always_ff @(posedge clk) begin
    if (shift) begin
      page <= next_page;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cpr_ctrl #(
  parameter int SLOTS = 16,
  parameter int PAGE_BITS = 20,
  localparam int SW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [4:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 command,
  input  wire logic [PAGE_BITS-1:0] page_number,
  input  wire logic                 is_write,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                outcome,
  output logic [SW-1:0]             slot,
  output logic [PAGE_BITS-1:0]      victim_page,
  output logic                      victim_dirty,
  output logic [SW-1:0]             hand_after,
  input  wire logic [SW-1:0]        head_slot,
  input  wire cpr_pkg::flags_t      head_flags,
  input  wire logic [PAGE_BITS-1:0] head_page,
  output logic                      shift,
  output logic [SW-1:0]             tail_slot,
  output cpr_pkg::flags_t           tail_flags,
  output logic [PAGE_BITS-1:0]      tail_page
);

  localparam int LW = (CW > 5) ? CW : 5;

  cpr_pkg::state_t   state, state_next;
  cpr_pkg::outcome_t res_outcome;

  logic [PAGE_BITS-1:0] key;
  logic                 cmd;
  logic                 wr;
  logic                 policy;
  logic [4:0]           limit;
  logic [SW-1:0]        lap;
  logic                 hit;
  logic [SW-1:0]        hit_slot;
  logic [CW-1:0]        fc;
  logic [SW-1:0]        hand;
  logic                 placing;
  logic [SW-1:0]        target;
  logic [CW-1:0]        step;
  logic                 phase;
  logic [SW-1:0]        res_slot;
  logic [PAGE_BITS-1:0] res_victim;
  logic                 res_dirty;

  logic          head_match;
  logic          lap_last;
  logic          hit_now;
  logic [SW-1:0] hit_slot_now;
  logic [LW-1:0] limit_ext;
  logic [LW-1:0] eff_limit;
  logic          room;
  logic [SW-1:0] start_slot;
  logic [CW-1:0] head_plus;
  logic [SW-1:0] hand_wrap;
  logic          step_last;
  logic          victim_now;
  logic          out_load;

  assign head_match   = head_flags.filled && (head_page == key);
  assign lap_last     = (lap == SW'(SLOTS - 1));
  assign hit_now      = hit || head_match;
  assign hit_slot_now = head_match ? head_slot : hit_slot;

  // a limit of zero acts as one, above the table size as the table size
  assign limit_ext = LW'(limit);
  always_comb begin
    if (limit_ext == '0) begin
      eff_limit = LW'(1);
    end else if (limit_ext > LW'(SLOTS)) begin
      eff_limit = LW'(SLOTS);
    end else begin
      eff_limit = limit_ext;
    end
  end

  assign room       = (LW'(fc) < eff_limit);
  assign start_slot = (CW'(hand) < fc) ? hand : '0;
  assign head_plus  = CW'(head_slot) + CW'(1);
  assign hand_wrap  = (head_plus == fc) ? '0 : SW'(head_plus);
  assign step_last  = (step == fc - CW'(1));
  assign out_load   = (state == cpr_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign in_stall   = (state != cpr_pkg::ST_IDLE);

  // ring control: every entry change goes in at the tail while the ring turns
  always_comb begin
    shift      = 1'b0;
    tail_slot  = head_slot;
    tail_flags = head_flags;
    tail_page  = head_page;
    victim_now = 1'b0;
    unique case (state)
      cpr_pkg::ST_LOOKUP: begin
        shift = 1'b1;
        if (head_match && cmd == cpr_pkg::CMD_ACCESS) begin
          tail_flags.used = 1'b1;
          if (wr) begin
            tail_flags.modified = 1'b1;
          end
        end
      end
      cpr_pkg::ST_SEEK: begin
        if (head_slot != target) begin
          shift = 1'b1;
        end else if (placing) begin
          shift               = 1'b1;
          tail_flags.filled   = 1'b1;
          tail_flags.used     = 1'b0;
          tail_flags.modified = 1'b0;
          tail_page           = key;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        shift = 1'b1;
        if (head_flags.filled) begin
          if (policy == cpr_pkg::POLICY_PLAIN || phase) begin
            victim_now = !head_flags.used;
          end else begin
            victim_now = !head_flags.used && !head_flags.modified;
          end
          if (victim_now) begin
            tail_flags.used     = 1'b0;
            tail_flags.modified = 1'b0;
            tail_page           = key;
          end else if (policy == cpr_pkg::POLICY_PLAIN || phase) begin
            tail_flags.used = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = cpr_pkg::ST_LOOKUP;
        end
      end
      cpr_pkg::ST_LOOKUP: begin
        if (lap_last) begin
          if (cmd == cpr_pkg::CMD_ACCESS || hit_now) begin
            state_next = cpr_pkg::ST_DONE;
          end else begin
            state_next = cpr_pkg::ST_SEEK;
          end
        end
      end
      cpr_pkg::ST_SEEK: begin
        if (head_slot == target) begin
          state_next = placing ? cpr_pkg::ST_DONE : cpr_pkg::ST_SWEEP;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (victim_now) begin
          state_next = cpr_pkg::ST_DONE;
        end
      end
      cpr_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = cpr_pkg::ST_IDLE;
        end
      end
      default: state_next = cpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpr_pkg::ST_IDLE;
      policy    <= cpr_pkg::POLICY_PLAIN;
      limit     <= cpr_pkg::LIMIT_RESET;
      fc        <= '0;
      hand      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          cpr_pkg::CFG_POLICY: policy <= cfg_data[0];
          cpr_pkg::CFG_LIMIT:  limit  <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (state == cpr_pkg::ST_SEEK && head_slot == target && placing) begin
        fc   <= fc + CW'(1);
        hand <= '0;
      end
      if (state == cpr_pkg::ST_SWEEP && victim_now) begin
        hand <= hand_wrap;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      cpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          key <= page_number;
          cmd <= command;
          wr  <= is_write;
          lap <= '0;
          hit <= 1'b0;
        end
      end
      cpr_pkg::ST_LOOKUP: begin
        lap <= lap + SW'(1);
        if (head_match) begin
          hit      <= 1'b1;
          hit_slot <= head_slot;
        end
        if (lap_last) begin
          res_victim <= '0;
          res_dirty  <= 1'b0;
          res_slot   <= hit_now ? hit_slot_now : '0;
          if (cmd == cpr_pkg::CMD_ACCESS) begin
            res_outcome <= hit_now ? cpr_pkg::OUT_ACC_HIT : cpr_pkg::OUT_ACC_MISS;
          end else begin
            res_outcome <= cpr_pkg::OUT_RESIDENT;
          end
          placing <= room;
          target  <= room ? SW'(fc) : start_slot;
          step    <= '0;
          phase   <= 1'b0;
        end
      end
      cpr_pkg::ST_SEEK: begin
        if (head_slot == target && placing) begin
          res_outcome <= cpr_pkg::OUT_PLACED;
          res_slot    <= target;
        end
      end
      cpr_pkg::ST_SWEEP: begin
        if (victim_now) begin
          res_outcome <= cpr_pkg::OUT_REPLACED;
          res_slot    <= head_slot;
          res_victim  <= head_page;
          res_dirty   <= head_flags.modified;
        end else if (head_flags.filled && policy == cpr_pkg::POLICY_MODIFIED) begin
          // one lap of the filled slots per phase
          if (step_last) begin
            step  <= '0;
            phase <= ~phase;
          end else begin
            step <= step + CW'(1);
          end
        end
      end
      cpr_pkg::ST_DONE: begin
        if (out_load) begin
          outcome      <= res_outcome;
          slot         <= res_slot;
          victim_page  <= res_victim;
          victim_dirty <= res_dirty;
          hand_after   <= hand;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_idle_still: assert property (@(posedge clk) disable iff (rst)
    state == cpr_pkg::ST_IDLE |-> !shift)
    else $error("ring turned while idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fc <= CW'(SLOTS))
    else $error("fill count beyond table size");

  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    hand == '0 || CW'(hand) < fc)
    else $error("hand beyond filled slots");

  a_sweep_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == cpr_pkg::ST_SWEEP |-> fc != '0)
    else $error("victim sweep on empty table");

  a_place_hand: assert property (@(posedge clk) disable iff (rst)
    (state == cpr_pkg::ST_SEEK && placing && head_slot == target) |=> hand == '0)
    else $error("hand not parked after placement");
`endif

endmodule

`default_nettype wire

FILE: test/tb_clock_page_replacement.sv
`timescale 1ns / 1ps

module tb_clock_page_replacement;

  localparam int SLOTS = 16;
  localparam int PAGE_BITS = 20;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOT_PAGES = 24;

  typedef enum logic [2:0] {
    REQ_PAGE,
    REQ_CFG,
    REQ_DRAIN,
    REQ_BLOCK,
    REQ_QUIET
  } req_kind_t;

  typedef struct packed {
    req_kind_t            kind;
    logic                 cmd;
    logic [PAGE_BITS-1:0] page;
    logic                 wr;
    logic                 idx;
    logic [4:0]           val;
  } request_t;

  typedef struct packed {
    cpr_pkg::outcome_t    outcome;
    logic [3:0]           slot;
    logic [PAGE_BITS-1:0] victim;
    logic                 dirty;
    logic [3:0]           hand;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic                 cfg_index = cpr_pkg::CFG_POLICY;
  logic [4:0]           cfg_data = 5'd0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 command = cpr_pkg::CMD_ACCESS;
  logic [PAGE_BITS-1:0] page_number = '0;
  logic                 is_write = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           outcome;
  logic [3:0]           slot;
  logic [PAGE_BITS-1:0] victim_page;
  logic                 victim_dirty;
  logic [3:0]           hand_after;

  clock_page_replacement #(
    .SLOTS(SLOTS),
    .PAGE_BITS(PAGE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .page_number(page_number),
    .is_write(is_write),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .outcome(outcome),
    .slot(slot),
    .victim_page(victim_page),
    .victim_dirty(victim_dirty),
    .hand_after(hand_after)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the working set
  logic [PAGE_BITS-1:0] resident_page [SLOTS];
  logic                 used_flag [SLOTS];
  logic                 dirty_flag [SLOTS];
  int                   fill_cnt = 0;
  int                   hand = 0;
  logic                 policy_sel = cpr_pkg::POLICY_PLAIN;
  logic [4:0]           limit_reg = cpr_pkg::LIMIT_RESET;

  request_t request_q[$];
  verdict_t verdict_q[$];

  int  n_in = 0, n_offered = 0, n_out = 0, n_cfg = 0;
  int  n_replaced = 0, n_dirty = 0, n_fail = 0;
  int  cycles = 0;
  int  send_gap = 0, settle = 0;
  int  hold_req = 0, hold_seen = 0, hold_left = 0, stall_left = 0;
  bit  idle_on = 1'b1;
  bit  stim_done = 1'b0;
  request_t cur_req;
  verdict_t want;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      resident_page[i] = '0;
      used_flag[i] = 1'b0;
      dirty_flag[i] = 1'b0;
    end
  end

  function automatic verdict_t serve_page(logic cmd, logic [PAGE_BITS-1:0] page, logic wr);
    verdict_t r;
    int hit, eff, n, p, i, round;
    bit found;
    r = '0;
    r.outcome = cpr_pkg::OUT_ACC_MISS;
    hit = -1;
    for (i = 0; i < fill_cnt; i++)
      if (hit < 0 && resident_page[i] == page) hit = i;
    eff = (limit_reg == 0) ? 1 : ((limit_reg > SLOTS) ? SLOTS : int'(limit_reg));
    if (cmd == cpr_pkg::CMD_ACCESS) begin
      if (hit >= 0) begin
        used_flag[hit] = 1'b1;
        if (wr) dirty_flag[hit] = 1'b1;
        r.outcome = cpr_pkg::OUT_ACC_HIT;
        r.slot = hit[3:0];
      end
    end else if (hit >= 0) begin
      r.outcome = cpr_pkg::OUT_RESIDENT;
      r.slot = hit[3:0];
    end else if (fill_cnt < eff) begin
      resident_page[fill_cnt] = page;
      used_flag[fill_cnt] = 1'b0;
      dirty_flag[fill_cnt] = 1'b0;
      r.outcome = cpr_pkg::OUT_PLACED;
      r.slot = fill_cnt[3:0];
      fill_cnt++;
      hand = 0;
    end else begin
      n = fill_cnt;
      p = (hand < n) ? hand : 0;
      found = 1'b0;
      if (policy_sel == cpr_pkg::POLICY_PLAIN) begin
        for (i = 0; i < 2 * n && !found; i++) begin
          if (!used_flag[p]) found = 1'b1;
          else begin
            used_flag[p] = 1'b0;
            p = (p + 1) % n;
          end
        end
      end else begin
        // two rounds: look for clean unused without clearing, then clear used bits
        for (round = 0; round < 2 && !found; round++) begin
          for (i = 0; i < n && !found; i++) begin
            if (!used_flag[p] && !dirty_flag[p]) found = 1'b1;
            else p = (p + 1) % n;
          end
          for (i = 0; i < n && !found; i++) begin
            if (!used_flag[p]) found = 1'b1;
            else begin
              used_flag[p] = 1'b0;
              p = (p + 1) % n;
            end
          end
        end
      end
      r.outcome = cpr_pkg::OUT_REPLACED;
      r.slot = p[3:0];
      r.victim = resident_page[p];
      r.dirty = dirty_flag[p];
      resident_page[p] = page;
      used_flag[p] = 1'b0;
      dirty_flag[p] = 1'b0;
      hand = (p + 1) % n;
    end
    r.hand = hand[3:0];
    return r;
  endfunction

  // Sample both channels and the register port
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (verdict_q.size() == 0) begin
          $error("result transfer with no request pending");
          n_fail++;
        end else begin
          want = verdict_q.pop_front();
          if (outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, outcome);
            n_fail++;
          end
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            n_fail++;
          end
          if (victim_page !== want.victim) begin
            $error("victim_page: expected %h, got %h", want.victim, victim_page);
            n_fail++;
          end
          if (victim_dirty !== want.dirty) begin
            $error("victim_dirty: expected %0d, got %0d", want.dirty, victim_dirty);
            n_fail++;
          end
          if (hand_after !== want.hand) begin
            $error("hand_after: expected %0d, got %0d", want.hand, hand_after);
            n_fail++;
          end
          if (want.outcome == cpr_pkg::OUT_REPLACED) n_replaced++;
          if (want.dirty) n_dirty++;
        end
      end
      if (cfg_write) begin
        n_cfg++;
        if (cfg_index == cpr_pkg::CFG_POLICY) policy_sel = cfg_data[0];
        else limit_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        n_in++;
        verdict_q.push_back(serve_page(command, page_number, is_write));
      end
    end
  end

  // Sender: pending requests go out one per transfer
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cfg_write) begin
      cfg_write <= 1'b0;
    end else if (in_valid && n_in != n_offered) begin
      // stalled, payload held
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (request_q.size() == 0) begin
      in_valid <= 1'b0;
      stim_done = 1'b1;
    end else if (request_q[0].kind == REQ_PAGE) begin
      cur_req = request_q.pop_front();
      command <= cur_req.cmd;
      page_number <= cur_req.page;
      is_write <= cur_req.wr;
      in_valid <= 1'b1;
      n_offered++;
      if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
    end else if (request_q[0].kind == REQ_QUIET) begin
      cur_req = request_q.pop_front();
      idle_on <= 1'b0;
      in_valid <= 1'b0;
    end else if (request_q[0].kind == REQ_BLOCK) begin
      cur_req = request_q.pop_front();
      hold_req <= hold_req + 1;
      in_valid <= 1'b0;
    end else if (verdict_q.size() != 0 || settle < 4) begin
      // register writes and drains wait for an empty pipe
      in_valid <= 1'b0;
      settle = (verdict_q.size() != 0) ? 0 : settle + 1;
    end else begin
      cur_req = request_q.pop_front();
      settle = 0;
      in_valid <= 1'b0;
      if (cur_req.kind == REQ_CFG) begin
        cfg_write <= 1'b1;
        cfg_index <= cur_req.idx;
        cfg_data <= cur_req.val;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_page(logic cmd, logic [PAGE_BITS-1:0] page, logic wr);
    request_t r;
    r = '0;
    r.kind = REQ_PAGE;
    r.cmd = cmd;
    r.page = page;
    r.wr = wr;
    request_q.push_back(r);
  endtask

  task automatic push_cfg(logic idx, logic [4:0] val);
    request_t r;
    r = '0;
    r.kind = REQ_CFG;
    r.idx = idx;
    r.val = val;
    request_q.push_back(r);
  endtask

  task automatic push_ctl(req_kind_t kind);
    request_t r;
    r = '0;
    r.kind = kind;
    request_q.push_back(r);
  endtask

  initial begin
    logic [PAGE_BITS-1:0] hot_pages [HOT_PAGES];
    logic [PAGE_BITS-1:0] pg;
    logic [4:0] phase_limit [6];
    int ph, k;

    // limit 0 acts as a one-entry table
    push_cfg(cpr_pkg::CFG_POLICY, 5'(cpr_pkg::POLICY_PLAIN));
    push_cfg(cpr_pkg::CFG_LIMIT, 5'd0);
    push_page(cpr_pkg::CMD_ACCESS, 20'h00000, 1'b1);
    push_page(cpr_pkg::CMD_FAULT, 20'h00000, 1'b0);
    push_page(cpr_pkg::CMD_ACCESS, 20'h00000, 1'b1);
    push_page(cpr_pkg::CMD_FAULT, 20'h00000, 1'b1);
    push_page(cpr_pkg::CMD_FAULT, 20'hFFFFF, 1'b0);
    push_page(cpr_pkg::CMD_ACCESS, 20'hFFFFF, 1'b0);
    push_page(cpr_pkg::CMD_FAULT, 20'h12345, 1'b0);
    push_cfg(cpr_pkg::CFG_LIMIT, 5'd3);
    push_page(cpr_pkg::CMD_FAULT, 20'h00001, 1'b0);
    push_page(cpr_pkg::CMD_FAULT, 20'h00002, 1'b0);
    push_page(cpr_pkg::CMD_ACCESS, 20'h00001, 1'b1);
    push_page(cpr_pkg::CMD_ACCESS, 20'h00002, 1'b0);
    // limit drops below the fill: replacement runs over all three slots
    push_cfg(cpr_pkg::CFG_LIMIT, 5'd1);
    push_cfg(cpr_pkg::CFG_POLICY, 5'(cpr_pkg::POLICY_MODIFIED));
    push_page(cpr_pkg::CMD_FAULT, 20'hAAAAA, 1'b0);
    push_page(cpr_pkg::CMD_ACCESS, 20'hAAAAA, 1'b1);
    push_page(cpr_pkg::CMD_FAULT, 20'h55555, 1'b0);
    push_page(cpr_pkg::CMD_ACCESS, 20'h55555, 1'b0);
    push_page(cpr_pkg::CMD_FAULT, 20'h0F0F0, 1'b1);
    // over-range limit clamps to the table size
    push_cfg(cpr_pkg::CFG_LIMIT, 5'd31);
    push_page(cpr_pkg::CMD_FAULT, 20'h00003, 1'b0);
    push_page(cpr_pkg::CMD_FAULT, 20'h00004, 1'b0);
    push_page(cpr_pkg::CMD_FAULT, 20'h00005, 1'b0);
    push_page(cpr_pkg::CMD_ACCESS, 20'h00005, 1'b1);
    push_page(cpr_pkg::CMD_FAULT, 20'h00004, 1'b0);
    push_page(cpr_pkg::CMD_ACCESS, 20'hFFFFE, 1'b1);

    hot_pages[0] = 20'h00000;
    hot_pages[1] = 20'hFFFFF;
    for (k = 2; k < HOT_PAGES; k++) hot_pages[k] = 20'($urandom);
    phase_limit[0] = 5'd4;
    phase_limit[1] = 5'd8;
    phase_limit[2] = 5'd2;
    phase_limit[3] = 5'd17;
    phase_limit[4] = 5'($urandom_range(0, 31));
    phase_limit[5] = cpr_pkg::LIMIT_RESET;

    for (ph = 0; ph < 6; ph++) begin
      push_cfg(cpr_pkg::CFG_POLICY, (ph % 2 == 1) ? 5'(cpr_pkg::POLICY_MODIFIED)
                                                  : 5'(cpr_pkg::POLICY_PLAIN));
      push_cfg(cpr_pkg::CFG_LIMIT, phase_limit[ph]);
      for (k = 0; k < 155; k++) begin
        if (ph == 2 && k == 60) push_ctl(REQ_BLOCK);
        if (ph == 3 && k == 80) push_ctl(REQ_DRAIN);
        if (ph == 5 && k == 95) push_ctl(REQ_QUIET);
        if ($urandom_range(0, 19) == 0) hot_pages[$urandom_range(2, HOT_PAGES - 1)] = 20'($urandom);
        // mostly a small set of pages so hits and resident faults are common
        pg = ($urandom_range(0, 9) < 7) ? hot_pages[$urandom_range(0, HOT_PAGES - 1)]
                                         : 20'($urandom);
        push_page(($urandom_range(0, 99) < 35) ? cpr_pkg::CMD_FAULT : cpr_pkg::CMD_ACCESS,
                  pg, 1'($urandom_range(0, 1)));
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(stim_done && verdict_q.size() == 0)) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Covered %0d page requests and %0d register writes, both sweep policies,",
             n_in, n_cfg);
    $display("with %0d results checked, %0d evictions and %0d dirty victims.",
             n_out, n_replaced, n_dirty);
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cpr_pkg.sv
rtl/cpr_cell.sv
rtl/cpr_ctrl.sv
rtl/clock_page_replacement.sv
test/tb_clock_page_replacement.sv
